// File: design/bpa_pkg.sv
// Shared types, constants and helper functions for the buddy page allocator.
// Used by bpa_ctrl, bpa_datapath and buddy_page_allocator_unit; depends on nothing.
package bpa_pkg;

    // Geometry of the managed page space.
    localparam int MAX_ORDER = 12;
    localparam int NPAGES    = 1 << MAX_ORDER;
    localparam int PAGE_W    = MAX_ORDER;
    localparam int LINK_W    = MAX_ORDER + 1;
    localparam int ORD_W     = 4;

    // List terminator: any link with the top bit set ends a list.
    localparam logic [LINK_W-1:0] EMPTY_MARK = LINK_W'(16'hFFFF);

    // Operation codes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Controller states, also used as datapath step commands.
    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_SWEEP   = 4'd0;
    localparam logic [ST_W-1:0] ST_IDLE    = 4'd1;
    localparam logic [ST_W-1:0] ST_DECODE  = 4'd2;
    localparam logic [ST_W-1:0] ST_A_POP   = 4'd3;
    localparam logic [ST_W-1:0] ST_A_SPLIT = 4'd4;
    localparam logic [ST_W-1:0] ST_F_CHK   = 4'd5;
    localparam logic [ST_W-1:0] ST_F_BUD   = 4'd6;
    localparam logic [ST_W-1:0] ST_F_BCHK  = 4'd7;
    localparam logic [ST_W-1:0] ST_U_RD    = 4'd8;
    localparam logic [ST_W-1:0] ST_U_CMP   = 4'd9;
    localparam logic [ST_W-1:0] ST_F_MERGE = 4'd10;
    localparam logic [ST_W-1:0] ST_F_PUSH  = 4'd11;
    localparam logic [ST_W-1:0] ST_FINISH  = 4'd12;

    // Request beat.
    typedef struct packed {
        logic              op;
        logic [12:0]       request_pages;
        logic [11:0]       page_index;
    } req_t;

    // Response beat.
    typedef struct packed {
        logic              status;
        logic [11:0]       block_index;
        logic [3:0]        granted_order;
    } rsp_t;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic [ST_W-1:0]   step;
        logic              accept;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic              sweep_done;
        logic              is_free_op;
        logic              alloc_fail;
        logic              free_skip;
        logic              at_target;
        logic              next_target;
        logic              page_free;
        logic              ord_top;
        logic              bud_out;
        logic              bud_match;
        logic              walk_stop;
        logic              walk_hit;
        logic              out_busy;
    } sts_t;

    // Smallest order whose block covers req pages (req is at least 1 when used).
    function automatic logic [ORD_W-1:0] ceil_order(input logic [LINK_W-1:0] req);
        logic [LINK_W-1:0] v;
        logic [ORD_W-1:0]  r;
        v = req - LINK_W'(1);
        r = '0;
        for (int i = 0; i < LINK_W; i++) begin
            if (v[i]) begin
                r = ORD_W'(i + 1);
            end
        end
        return r;
    endfunction

    // Position of the highest set bit.
    function automatic logic [ORD_W-1:0] floor_order(input logic [LINK_W-1:0] v);
        logic [ORD_W-1:0] r;
        r = '0;
        for (int i = 0; i < LINK_W; i++) begin
            if (v[i]) begin
                r = ORD_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// File: design/bpa_ctrl.sv
// Sequencing state machine of the buddy page allocator.
// Depends on bpa_pkg for state codes and the command and status structs.
module bpa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic           req_valid,
    output logic           req_stall,
    output bpa_pkg::cmd_t  cmd,
    input  bpa_pkg::sts_t  sts
);

    logic [bpa_pkg::ST_W-1:0] state_reg;
    logic [bpa_pkg::ST_W-1:0] state_next;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bpa_pkg::ST_SWEEP:
            begin
                if (sts.sweep_done) state_next = bpa_pkg::ST_IDLE;
            end
            bpa_pkg::ST_IDLE:
            begin
                if (req_valid) state_next = bpa_pkg::ST_DECODE;
            end
            bpa_pkg::ST_DECODE:
            begin
                if (sts.is_free_op) begin
                    state_next = sts.free_skip ? bpa_pkg::ST_FINISH : bpa_pkg::ST_F_CHK;
                end else begin
                    state_next = sts.alloc_fail ? bpa_pkg::ST_FINISH : bpa_pkg::ST_A_POP;
                end
            end
            bpa_pkg::ST_A_POP:
            begin
                state_next = sts.at_target ? bpa_pkg::ST_FINISH : bpa_pkg::ST_A_SPLIT;
            end
            bpa_pkg::ST_A_SPLIT:
            begin
                if (sts.next_target) state_next = bpa_pkg::ST_FINISH;
            end
            bpa_pkg::ST_F_CHK:
            begin
                state_next = sts.page_free ? bpa_pkg::ST_FINISH : bpa_pkg::ST_F_BUD;
            end
            bpa_pkg::ST_F_BUD:
            begin
                if (sts.ord_top || sts.bud_out) state_next = bpa_pkg::ST_F_PUSH;
                else                            state_next = bpa_pkg::ST_F_BCHK;
            end
            bpa_pkg::ST_F_BCHK:
            begin
                state_next = sts.bud_match ? bpa_pkg::ST_U_RD : bpa_pkg::ST_F_PUSH;
            end
            bpa_pkg::ST_U_RD:
            begin
                state_next = sts.walk_stop ? bpa_pkg::ST_F_MERGE : bpa_pkg::ST_U_CMP;
            end
            bpa_pkg::ST_U_CMP:
            begin
                state_next = sts.walk_hit ? bpa_pkg::ST_F_MERGE : bpa_pkg::ST_U_RD;
            end
            bpa_pkg::ST_F_MERGE:
            begin
                state_next = bpa_pkg::ST_F_BUD;
            end
            bpa_pkg::ST_F_PUSH:
            begin
                state_next = bpa_pkg::ST_FINISH;
            end
            bpa_pkg::ST_FINISH:
            begin
                if (!sts.out_busy) state_next = bpa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bpa_pkg::ST_SWEEP;
            end
        endcase
        // A page_total write restarts the rebuild sweep.
        if (cfg_we) state_next = bpa_pkg::ST_SWEEP;
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= bpa_pkg::ST_SWEEP;
        else        state_reg <= state_next;
    end

    // Commands and the request handshake.
    assign req_stall  = (state_reg != bpa_pkg::ST_IDLE);
    assign cmd.step   = state_reg;
    assign cmd.accept = (state_reg == bpa_pkg::ST_IDLE) && req_valid;

endmodule

// File: design/bpa_datapath.sv
// Datapath of the buddy page allocator: page info and link memories, list heads,
// working registers and the response register. Depends on bpa_pkg.
module bpa_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [12:0]    cfg_data,
    input  bpa_pkg::req_t  req_data,
    input  logic           rsp_stall,
    output logic           rsp_valid,
    output bpa_pkg::rsp_t  rsp_data,
    input  bpa_pkg::cmd_t  cmd,
    output bpa_pkg::sts_t  sts
);

    localparam int MO = bpa_pkg::MAX_ORDER;
    localparam int PW = bpa_pkg::PAGE_W;
    localparam int LW = bpa_pkg::LINK_W;
    localparam int OW = bpa_pkg::ORD_W;
    localparam int NP = bpa_pkg::NPAGES;

    // One page info word: free flag and stored order.
    typedef struct packed {
        logic          free;
        logic [OW-1:0] ord;
    } info_t;

    // Storage.
    info_t         info_mem [0:NP-1];
    logic [LW-1:0] link_mem [0:NP-1];
    info_t         info_rdata_reg;
    logic [LW-1:0] link_rdata_reg;
    logic [LW-1:0] head_reg [0:MO];

    // Control registers.
    logic [LW-1:0] page_total_reg;
    logic [PW-1:0] sweep_addr_reg;
    logic [LW-1:0] carve_ptr_reg;
    logic [LW-1:0] remain_reg;
    logic          out_valid_reg;

    // Working registers.
    logic          op_reg;
    logic [LW-1:0] req_reg;
    logic [PW-1:0] idx_reg;
    logic [OW-1:0] tgt_reg;
    logic [OW-1:0] ord_reg;
    logic [PW-1:0] bud_reg;
    logic [LW-1:0] cur_reg;
    logic [PW-1:0] prev_reg;
    logic          first_reg;
    logic [LW-1:0] steps_reg;
    bpa_pkg::rsp_t res_reg;
    bpa_pkg::rsp_t rsp_data_reg;

    // Memory port signals.
    logic          info_we;
    logic [PW-1:0] info_waddr;
    info_t         info_wdata;
    logic [PW-1:0] info_raddr;
    logic          link_we;
    logic [PW-1:0] link_waddr;
    logic [LW-1:0] link_wdata;
    logic [PW-1:0] link_raddr;

    // Derived values.
    logic [LW-1:0] cfg_val;
    logic [OW-1:0] carve_ord;
    logic          carve_hit;
    logic [OW-1:0] tgt_c;
    logic          found_c;
    logic [OW-1:0] sel_c;
    logic [OW-1:0] ord_m1;
    logic [PW-1:0] bud_c;
    logic [PW-1:0] bud_s;
    logic          load_out;

    // Clamp the written page count into the managed range.
    always_comb
    begin
        if (cfg_data == '0)                  cfg_val = LW'(1);
        else if (cfg_data > LW'(NP))         cfg_val = LW'(NP);
        else                                 cfg_val = cfg_data;
    end

    // Greedy carving: the next block start takes the largest power of two left.
    assign carve_ord = bpa_pkg::floor_order(remain_reg);
    assign carve_hit = (remain_reg != '0) && ({1'b0, sweep_addr_reg} == carve_ptr_reg);

    // Target order and the first non-empty list at or above it.
    assign tgt_c = bpa_pkg::ceil_order(req_reg);
    always_comb
    begin
        found_c = 1'b0;
        sel_c   = '0;
        for (int o = MO; o >= 0; o--)
        begin
            if ((OW'(o) >= tgt_c) && !head_reg[o][PW])
            begin
                found_c = 1'b1;
                sel_c   = OW'(o);
            end
        end
    end

    // Buddy addresses for merging and for splitting.
    assign ord_m1 = ord_reg - OW'(1);
    assign bud_c  = idx_reg ^ (PW'(1) << ord_reg);
    assign bud_s  = idx_reg ^ (PW'(1) << ord_m1);

    // Memory port control per step.
    always_comb
    begin
        info_we    = 1'b0;
        info_waddr = idx_reg;
        info_wdata = '0;
        info_raddr = idx_reg;
        link_we    = 1'b0;
        link_waddr = idx_reg;
        link_wdata = head_reg[ord_reg];
        link_raddr = cur_reg[PW-1:0];
        case (cmd.step)
            bpa_pkg::ST_SWEEP:
            begin
                info_we    = 1'b1;
                info_waddr = sweep_addr_reg;
                info_wdata = carve_hit ? info_t'{free: 1'b1, ord: carve_ord} : '0;
                link_we    = carve_hit;
                link_waddr = sweep_addr_reg;
                link_wdata = bpa_pkg::EMPTY_MARK;
            end
            bpa_pkg::ST_DECODE:
            begin
                link_raddr = head_reg[sel_c][PW-1:0];
            end
            bpa_pkg::ST_A_POP:
            begin
                info_we    = 1'b1;
                info_wdata = info_t'{free: 1'b0, ord: tgt_reg};
            end
            bpa_pkg::ST_A_SPLIT:
            begin
                info_we    = 1'b1;
                info_waddr = bud_s;
                info_wdata = info_t'{free: 1'b1, ord: ord_m1};
                link_we    = 1'b1;
                link_waddr = bud_s;
                link_wdata = head_reg[ord_m1];
            end
            bpa_pkg::ST_F_BUD:
            begin
                info_raddr = bud_c;
            end
            bpa_pkg::ST_F_BCHK:
            begin
                info_we    = sts.bud_match;
                info_waddr = bud_reg;
                info_wdata = info_t'{free: 1'b0, ord: ord_reg};
            end
            bpa_pkg::ST_U_CMP:
            begin
                link_we    = sts.walk_hit && !first_reg;
                link_waddr = prev_reg;
                link_wdata = link_rdata_reg;
            end
            bpa_pkg::ST_F_PUSH:
            begin
                info_we    = 1'b1;
                info_wdata = info_t'{free: 1'b1, ord: ord_reg};
                link_we    = 1'b1;
            end
            default:
            begin
                info_we = 1'b0;
            end
        endcase
    end

    // Page info and link memories with registered reads.
    always_ff @(posedge clk)
    begin
        if (info_we) info_mem[info_waddr] <= info_wdata;
        info_rdata_reg <= info_mem[info_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (link_we) link_mem[link_waddr] <= link_wdata;
        link_rdata_reg <= link_mem[link_raddr];
    end

    // A finished result moves to the response register once it is free.
    assign load_out = (cmd.step == bpa_pkg::ST_FINISH) && !sts.out_busy;

    // List heads, page count, rebuild sweep and response valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int o = 0; o <= MO; o++) head_reg[o] <= bpa_pkg::EMPTY_MARK;
            page_total_reg <= LW'(NP);
            remain_reg     <= LW'(NP);
            carve_ptr_reg  <= '0;
            sweep_addr_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load_out)       out_valid_reg <= 1'b1;
            else if (!rsp_stall) out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                for (int o = 0; o <= MO; o++) head_reg[o] <= bpa_pkg::EMPTY_MARK;
                page_total_reg <= cfg_val;
                remain_reg     <= cfg_val;
                carve_ptr_reg  <= '0;
                sweep_addr_reg <= '0;
            end
            else
            begin
                case (cmd.step)
                    bpa_pkg::ST_SWEEP:
                    begin
                        sweep_addr_reg <= sweep_addr_reg + PW'(1);
                        if (carve_hit)
                        begin
                            head_reg[carve_ord] <= {1'b0, sweep_addr_reg};
                            carve_ptr_reg       <= carve_ptr_reg + (LW'(1) << carve_ord);
                            remain_reg          <= remain_reg - (LW'(1) << carve_ord);
                        end
                    end
                    bpa_pkg::ST_A_POP:
                    begin
                        head_reg[ord_reg] <= link_rdata_reg;
                    end
                    bpa_pkg::ST_A_SPLIT:
                    begin
                        head_reg[ord_m1] <= {1'b0, bud_s};
                    end
                    bpa_pkg::ST_U_CMP:
                    begin
                        if (sts.walk_hit && first_reg) head_reg[ord_reg] <= link_rdata_reg;
                    end
                    bpa_pkg::ST_F_PUSH:
                    begin
                        head_reg[ord_reg] <= {1'b0, idx_reg};
                    end
                    default:
                    begin
                        remain_reg <= remain_reg;
                    end
                endcase
            end
        end
    end

    // Working registers of the item in flight and the response data register.
    always_ff @(posedge clk)
    begin
        if (load_out) rsp_data_reg <= res_reg;
        case (cmd.step)
            bpa_pkg::ST_IDLE:
            begin
                if (cmd.accept)
                begin
                    op_reg  <= req_data.op;
                    req_reg <= req_data.request_pages;
                    idx_reg <= req_data.page_index;
                end
            end
            bpa_pkg::ST_DECODE:
            begin
                tgt_reg <= tgt_c;
                res_reg <= '{status: (op_reg == bpa_pkg::OP_ALLOC) && sts.alloc_fail,
                             block_index: '0, granted_order: '0};
                if (op_reg == bpa_pkg::OP_ALLOC)
                begin
                    idx_reg <= head_reg[sel_c][PW-1:0];
                    ord_reg <= sel_c;
                end
            end
            bpa_pkg::ST_A_POP:
            begin
                res_reg <= '{status: 1'b0, block_index: idx_reg, granted_order: tgt_reg};
            end
            bpa_pkg::ST_A_SPLIT:
            begin
                ord_reg <= ord_m1;
            end
            bpa_pkg::ST_F_CHK:
            begin
                ord_reg <= (info_rdata_reg.ord > OW'(MO)) ? OW'(MO) : info_rdata_reg.ord;
            end
            bpa_pkg::ST_F_BUD:
            begin
                bud_reg <= bud_c;
            end
            bpa_pkg::ST_F_BCHK:
            begin
                cur_reg   <= head_reg[ord_reg];
                first_reg <= 1'b1;
                steps_reg <= '0;
            end
            bpa_pkg::ST_U_CMP:
            begin
                if (!sts.walk_hit)
                begin
                    prev_reg  <= cur_reg[PW-1:0];
                    first_reg <= 1'b0;
                    cur_reg   <= link_rdata_reg;
                    steps_reg <= steps_reg + LW'(1);
                end
            end
            bpa_pkg::ST_F_MERGE:
            begin
                if (bud_reg < idx_reg) idx_reg <= bud_reg;
                ord_reg <= ord_reg + OW'(1);
            end
            bpa_pkg::ST_F_PUSH:
            begin
                res_reg <= '{status: 1'b0, block_index: '0, granted_order: ord_reg};
            end
            default:
            begin
                op_reg <= op_reg;
            end
        endcase
    end

    // Status back to the controller.
    assign sts.sweep_done  = &sweep_addr_reg;
    assign sts.is_free_op  = (op_reg == bpa_pkg::OP_FREE);
    assign sts.alloc_fail  = (req_reg == '0) || (req_reg > page_total_reg) || !found_c;
    assign sts.free_skip   = ({1'b0, idx_reg} >= page_total_reg);
    assign sts.at_target   = (ord_reg == tgt_reg);
    assign sts.next_target = (ord_m1 == tgt_reg);
    assign sts.page_free   = info_rdata_reg.free;
    assign sts.ord_top     = (ord_reg == OW'(MO));
    assign sts.bud_out     = ({1'b0, bud_c} >= page_total_reg);
    assign sts.bud_match   = info_rdata_reg.free && (info_rdata_reg.ord == ord_reg);
    assign sts.walk_stop   = cur_reg[PW] || steps_reg[PW];
    assign sts.walk_hit    = (cur_reg == {1'b0, bud_reg});
    assign sts.out_busy    = out_valid_reg && rsp_stall;

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

// File: design/buddy_page_allocator_unit.sv
// Buddy page allocator, top level, one item at a time. An allocate takes the smallest
// non-empty free list at or above the target order and splits the block down to it. A free
// merges the block with its free buddy level by level, walking the buddy's list to unlink
// it, then pushes the block; a free of a page out of range or already free is ignored.
// The result becomes valid as the unit returns to idle and waits in an output register.
// Reset and each page_total write start a rebuild sweep. Uses bpa_pkg/ctrl/datapath.
module buddy_page_allocator_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [12:0]    cfg_data,
    input  logic           req_valid,
    output logic           req_stall,
    input  bpa_pkg::req_t  req_data,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output bpa_pkg::rsp_t  rsp_data
);

    bpa_pkg::cmd_t cmd;
    bpa_pkg::sts_t sts;

    // Sequencer.
    bpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Storage and arithmetic.
    bpa_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .req_data  (req_data),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    // A page_total write starts a rebuild, so requests stall right after it.
    a_cfg_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> req_stall)
        else $error("request not stalled during rebuild");

    // Only one item is in flight: an accepted beat stalls the next cycle.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && !cfg_we) |=> req_stall)
        else $error("second beat taken while busy");

    // A new response appears only as an item finishes.
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("response raised without an item in flight");

endmodule
